/* hdl/bidd_pkg.sv */
`default_nettype none

package bidd_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned TotalBits  = 17;

  typedef enum logic [0:0] {
    CFG_SPS   = 1'b0,
    CFG_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_DECISION = 1'b0,
    KIND_SUMMARY  = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_real;
    logic                         expected_bit;
    logic                         capture_end;
  } bidd_in_t;

  typedef struct packed {
    logic                 result_kind;
    logic                 decided_bit;
    logic                 bit_mismatch;
    logic [TotalBits-1:0] error_total;
    logic [TotalBits-1:0] bit_total;
    logic                 trial_decoded;
    logic                 run_last;
  } bidd_out_t;

  // everything one accepted sample produces
  typedef struct packed {
    logic                 has_dec;
    logic                 decided_bit;
    logic                 bit_mismatch;
    logic [TotalBits-1:0] dec_errors;
    logic                 has_sum;
    logic [TotalBits-1:0] sum_errors;
    logic [TotalBits-1:0] sum_bits;
    logic                 sum_decoded;
  } bidd_entry_t;

endpackage

`default_nettype wire

/* hdl/bidd_detector.sv */
`default_nettype none

module bidd_detector import bidd_pkg::*; #(
  parameter int unsigned MAX_SPS           = 64,
  parameter int unsigned MAX_PAYLOAD_BYTES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire bidd_in_t    item_i,
  input  wire logic [6:0]  sps_i,
  input  wire logic [13:0] bytes_i,
  output logic             push_o,
  output bidd_entry_t      entry_o
);

  localparam int unsigned CntW   = $clog2(MAX_SPS + 1);
  localparam int unsigned BitsW  = $clog2(MAX_PAYLOAD_BYTES * 8 + 1);
  localparam int unsigned IntegW = SampleBits + $clog2(MAX_SPS);

  logic signed [IntegW-1:0] integ_q, integ_d, integ_sum;
  logic [CntW-1:0]          cnt_q, cnt_d, cnt_inc;
  logic [BitsW-1:0]         sym_q, sym_d, sym_inc;
  logic [BitsW-1:0]         err_q, err_d, err_new;
  logic [CntW-1:0]          sps_eff;
  logic [31:0]              bytes_eff;
  logic [BitsW-1:0]         exp_bits;
  logic                     active, decide, decided, mis, complete;

  always_comb begin
    if (sps_i == 7'd0) begin
      sps_eff = CntW'(1);
    end else if (32'(sps_i) > MAX_SPS) begin
      sps_eff = CntW'(MAX_SPS);
    end else begin
      sps_eff = CntW'(sps_i);
    end
    if (32'(bytes_i) > MAX_PAYLOAD_BYTES) begin
      bytes_eff = 32'(MAX_PAYLOAD_BYTES);
    end else begin
      bytes_eff = 32'(bytes_i);
    end
    exp_bits = BitsW'(bytes_eff << 3);

    active    = sym_q < exp_bits;
    integ_sum = integ_q + IntegW'(item_i.sample_real);
    cnt_inc   = cnt_q + CntW'(1);
    decide    = active && (cnt_inc >= sps_eff);
    decided   = !integ_sum[IntegW-1];
    mis       = decided != item_i.expected_bit;
    err_new   = err_q + BitsW'(decide && mis);
    sym_inc   = sym_q + BitsW'(decide);
    complete  = sym_inc >= exp_bits;

    integ_d = integ_q;
    cnt_d   = cnt_q;
    sym_d   = sym_q;
    err_d   = err_q;
    if (accept_i) begin
      if (active) begin
        integ_d = decide ? '0 : integ_sum;
        cnt_d   = decide ? '0 : cnt_inc;
        sym_d   = sym_inc;
        err_d   = err_new;
      end
      if (item_i.capture_end) begin
        integ_d = '0;
        cnt_d   = '0;
        sym_d   = '0;
        err_d   = '0;
      end
    end

    push_o               = accept_i && (decide || item_i.capture_end);
    entry_o.has_dec      = decide;
    entry_o.decided_bit  = decided;
    entry_o.bit_mismatch = mis;
    entry_o.dec_errors   = TotalBits'(err_new);
    entry_o.has_sum      = item_i.capture_end;
    entry_o.sum_errors   = complete ? TotalBits'(err_new) : TotalBits'(exp_bits);
    entry_o.sum_bits     = TotalBits'(exp_bits);
    entry_o.sum_decoded  = complete && (err_new == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      cnt_q   <= '0;
      sym_q   <= '0;
      err_q   <= '0;
    end else begin
      integ_q <= integ_d;
      cnt_q   <= cnt_d;
      sym_q   <= sym_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/bidd_out_queue.sv */
`default_nettype none

module bidd_out_queue import bidd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire bidd_entry_t entry_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output bidd_out_t        out_data_o
);

  bidd_entry_t mem_q [2];
  bidd_entry_t head;
  logic        wr_ptr_q, rd_ptr_q, phase_q, phase_d;
  logic [1:0]  count_q, count_d;
  logic        show_dec, take, pop;

  always_comb begin
    head        = mem_q[rd_ptr_q];
    full_o      = count_q == 2'd2;
    out_valid_o = count_q != 2'd0;
    show_dec    = head.has_dec && !phase_q;
    take        = out_valid_o && !out_stall_i;
    pop         = take && !(show_dec && head.has_sum);

    if (show_dec) begin
      out_data_o.result_kind   = KIND_DECISION;
      out_data_o.decided_bit   = head.decided_bit;
      out_data_o.bit_mismatch  = head.bit_mismatch;
      out_data_o.error_total   = head.dec_errors;
      out_data_o.bit_total     = '0;
      out_data_o.trial_decoded = 1'b0;
      out_data_o.run_last      = !head.has_sum;
    end else begin
      out_data_o.result_kind   = KIND_SUMMARY;
      out_data_o.decided_bit   = 1'b0;
      out_data_o.bit_mismatch  = 1'b0;
      out_data_o.error_total   = head.sum_errors;
      out_data_o.bit_total     = head.sum_bits;
      out_data_o.trial_decoded = head.sum_decoded;
      out_data_o.run_last      = 1'b1;
    end

    phase_d = phase_q;
    if (pop) begin
      phase_d = 1'b0;
    end else if (take) begin
      phase_d = 1'b1;
    end
    count_d = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      phase_q  <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q ^ push_i;
      rd_ptr_q <= rd_ptr_q ^ pop;
      phase_q  <= phase_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/bpsk_integrate_dump_ber_checker_core.sv */
// Results are registered in a two-entry output queue and offered in order.
// Throughput: one sample per cycle while the queue is not full; a sample that
// yields a decision and a summary is offered as the decision, then the summary.
// Reset (rst_ni low, async): trial counters and integrator clear, queue
// empties, the oversampling and payload length registers return to 1.
`default_nettype none

module bpsk_integrate_dump_ber_checker_core import bidd_pkg::*; #(
  parameter int unsigned MAX_SPS           = 64,
  parameter int unsigned MAX_PAYLOAD_BYTES = 8192
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire bidd_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output bidd_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire cfg_idx_e  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [6:0]  sps_q;
  logic [13:0] bytes_q;
  logic        full, accept, push;
  bidd_entry_t entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q   <= 7'd1;
      bytes_q <= 14'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPS:   sps_q   <= cfg_data_i[6:0];
        CFG_BYTES: bytes_q <= cfg_data_i[13:0];
        default:   ;
      endcase
    end
  end

  bidd_detector #(
    .MAX_SPS           (MAX_SPS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_detector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .sps_i    (sps_q),
    .bytes_i  (bytes_q),
    .push_o   (push),
    .entry_o  (entry)
  );

  bidd_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* hdl/bidd_checker.sv */
`default_nettype none

module bidd_checker import bidd_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_stall_i,
  input wire bidd_out_t out_data_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled request changed");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.result_kind == KIND_SUMMARY) |-> out_data_i.run_last)
    else $error("summary not last of its run");

  a_decision_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.result_kind == KIND_DECISION)
      |-> (out_data_i.bit_total == '0) && !out_data_i.trial_decoded)
    else $error("decision carries summary fields");

  a_decoded_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.trial_decoded |-> (out_data_i.error_total == '0))
    else $error("decoded trial with errors");

endmodule

bind bpsk_integrate_dump_ber_checker_core bidd_checker u_bidd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

/* dv/bidd_ber_check.sv */
`timescale 1ns / 100ps

module bidd_ber_check import bidd_pkg::*; #(
  parameter int unsigned MAX_SPS           = 64,
  parameter int unsigned MAX_PAYLOAD_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  bidd_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  bidd_out_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_idx_e    cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned decisions_o,
  output int unsigned summaries_o
);

  logic [6:0]         sps_reg;
  logic [13:0]        bytes_reg;
  logic signed [21:0] integ;
  int unsigned        samples_in_sym;
  int unsigned        symbols_done;
  int unsigned        err_tally;
  bidd_out_t          due_results[$];

  task automatic clear_trial();
    integ          = '0;
    samples_in_sym = 0;
    symbols_done   = 0;
    err_tally      = 0;
  endtask

  task automatic integrate_and_decide(input bidd_in_t d);
    int unsigned sps;
    int unsigned bytes;
    int unsigned bits;
    bidd_out_t   r;
    sps = sps_reg;
    if (sps == 0) sps = 1;
    if (sps > MAX_SPS) sps = MAX_SPS;
    bytes = bytes_reg;
    if (bytes > MAX_PAYLOAD_BYTES) bytes = MAX_PAYLOAD_BYTES;
    bits = bytes * 8;

    if (symbols_done < bits) begin
      integ = integ + $signed(d.sample_real);
      samples_in_sym++;
      if (samples_in_sym >= sps) begin
        r              = '0;
        r.result_kind  = KIND_DECISION;
        r.decided_bit  = (integ >= 0);
        r.bit_mismatch = (r.decided_bit != d.expected_bit);
        err_tally      += r.bit_mismatch;
        symbols_done++;
        integ          = '0;
        samples_in_sym = 0;
        r.error_total  = 17'(err_tally);
        r.run_last     = !d.capture_end;
        due_results    = {due_results, r};
      end
    end

    // short capture: every payload bit counts as wrong
    if (d.capture_end) begin
      r               = '0;
      r.result_kind   = KIND_SUMMARY;
      r.error_total   = (symbols_done >= bits) ? 17'(err_tally) : 17'(bits);
      r.bit_total     = 17'(bits);
      r.trial_decoded = (symbols_done >= bits) && (err_tally == 0);
      r.run_last      = 1'b1;
      due_results     = {due_results, r};
      clear_trial();
    end
  endtask

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bidd_out_t want;
    if (!rst_ni) begin
      sps_reg      = 7'd1;
      bytes_reg    = 14'd1;
      clear_trial();
      due_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      decisions_o  = 0;
      summaries_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SPS) sps_reg = cfg_data_i[6:0];
        else bytes_reg = cfg_data_i[13:0];
      end
      if (in_valid_i && !in_stall_i) integrate_and_decide(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d errors %0d bits %0d",
                 out_data_i.result_kind, out_data_i.error_total, out_data_i.bit_total);
          fail_count_o++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.result_kind, out_data_i.result_kind);
          check_field("decided_bit", want.decided_bit, out_data_i.decided_bit);
          check_field("bit_mismatch", want.bit_mismatch, out_data_i.bit_mismatch);
          check_field("error_total", want.error_total, out_data_i.error_total);
          check_field("bit_total", want.bit_total, out_data_i.bit_total);
          check_field("trial_decoded", want.trial_decoded, out_data_i.trial_decoded);
          check_field("run_last", want.run_last, out_data_i.run_last);
          if (want.result_kind == KIND_DECISION) decisions_o++;
          else summaries_o++;
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

/* dv/bpsk_integrate_dump_ber_checker_core_tb.sv */
`timescale 1ns / 100ps

module bpsk_integrate_dump_ber_checker_core_tb;
  import bidd_pkg::*;

  localparam int unsigned RandSamples = 950;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bidd_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  bidd_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_e    cfg_index;
  logic [15:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned decisions;
  int unsigned summaries;

  int unsigned cycles;
  int unsigned samples_sent;
  int unsigned reg_writes;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned eff_sps;
  int unsigned eff_bits;

  bpsk_integrate_dump_ber_checker_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  bidd_ber_check ber_mon (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .decisions_o (decisions),
    .summaries_o (summaries)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("bpsk_integrate_dump_ber_checker_core_tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  task automatic push_sample(input logic signed [15:0] s, input logic b, input logic e);
    if (samples_sent < (RandSamples + 25) / 3) begin
      send_idle_pct  = 25;
      recv_stall_pct = 79;
    end else if (samples_sent < 2 * (RandSamples + 25) / 3) begin
      send_idle_pct  = 79;
      recv_stall_pct = 25;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{sample_real: s, expected_bit: b, capture_end: e};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    reg_writes++;
  endtask

  // wait for all results, then cover samples that produce none
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input int unsigned sps, input int unsigned bytes);
    logic [15:0] junk;
    settle();
    junk = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
    write_reg(CFG_SPS, {junk[15:7], sps[6:0]});
    write_reg(CFG_BYTES, {junk[1:0], bytes[13:0]});
    eff_sps = (sps[6:0] == 0) ? 1 : (sps[6:0] > 64 ? 64 : sps[6:0]);
    eff_bits = (bytes[13:0] > 8192 ? 8192 : bytes[13:0]) * 8;
  endtask

  task automatic run_capture();
    int unsigned total;
    int unsigned n;
    int unsigned flavor;
    int unsigned shape;
    int unsigned cap;
    logic        with_end;
    logic        b;
    logic        e;
    logic signed [15:0] s;
    total    = eff_bits * eff_sps;
    flavor   = $urandom_range(0, 9);
    shape    = $urandom_range(0, 10);
    with_end = 1'b1;
    b        = 1'b0;
    if (shape == 10) begin
      n = $urandom_range(1, 6);
    end else if (total == 0) begin
      n = $urandom_range(1, 5);
    end else if (total > 600 || shape inside {6, 7}) begin
      cap = 3 * eff_sps + 5;
      if (cap > total - 1) cap = total - 1;
      n = $urandom_range(1, cap);
    end else if (shape == 8) begin
      n = total + $urandom_range(1, 5);
    end else begin
      n = total;
      with_end = (shape != 9);
    end
    for (int i = 0; i < n; i++) begin
      if (i % eff_sps == 0) b = $urandom_range(0, 1);
      if (shape == 10 || flavor inside {5, 6, 7}) begin
        s = 16'($urandom);
      end else if (flavor inside {8, 9}) begin
        s = 16'($urandom_range(0, 6)) - 16'sd3;
      end else begin
        s = 16'($urandom_range(0, 32767));
        if (!b) s = ~s;
      end
      if (shape == 10) begin
        b = $urandom_range(0, 1);
        e = ($urandom_range(0, 7) == 0);
      end else begin
        e = with_end && (i == n - 1);
      end
      push_sample(s, b, e);
    end
  endtask

  initial begin
    logic [7:0]  pat;
    int unsigned sps;
    int unsigned bytes;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_SPS;
    cfg_data       = '0;
    out_stall      = 1'b0;
    cycles         = 0;
    samples_sent   = 0;
    reg_writes     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    eff_sps        = 1;
    eff_bits       = 8;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: one sample per bit, one byte
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh8000, 1'b0, 1'b0);
    push_sample(16'sd0, 1'b1, 1'b0);
    push_sample(16'sd0, 1'b0, 1'b0);
    push_sample(-16'sd1, 1'b1, 1'b0);
    push_sample(16'sd1, 1'b0, 1'b0);
    push_sample(16'sd12345, 1'b1, 1'b0);
    push_sample(-16'sd12345, 1'b0, 1'b0);
    push_sample(16'sd500, 1'b1, 1'b0);
    push_sample(-16'sd7, 1'b0, 1'b1);
    // short capture, end on a decided symbol
    push_sample(16'sd100, 1'b1, 1'b0);
    push_sample(-16'sd100, 1'b0, 1'b0);
    push_sample(16'sd100, 1'b0, 1'b1);
    // clean full capture
    pat = 8'hb2;
    for (int i = 0; i < 8; i++) begin
      push_sample(pat[7 - i] ? 16'sd20000 : -16'sd20000, pat[7 - i], i == 7);
    end
    // zero oversampling, empty payload
    configure(0, 0);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh8000, 1'b0, 1'b1);
    // both registers above their limits
    configure(127, 16383);
    push_sample(16'sh7fff, 1'b1, 1'b0);
    push_sample(16'sh7fff, 1'b1, 1'b1);

    while (samples_sent < RandSamples + 25) begin
      case ($urandom_range(0, 15))
        0:       sps = 0;
        1:       sps = 64;
        2:       sps = $urandom_range(65, 127);
        3:       sps = 63;
        default: sps = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 15))
        0:       bytes = 0;
        1:       bytes = 8192;
        2:       bytes = $urandom_range(8193, 16383);
        default: bytes = $urandom_range(1, 3);
      endcase
      configure(sps, bytes);
      repeat ($urandom_range(1, 3)) run_capture();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("%0d samples sent over %0d register writes", samples_sent, reg_writes);
    $display("%0d bit decisions and %0d trial summaries compared", decisions, summaries);
    if (fail_count == 0 && pending == 0) begin
      $display("bpsk_integrate_dump_ber_checker_core_tb: clean");
    end else begin
      $display("bpsk_integrate_dump_ber_checker_core_tb: errors");
    end
    $finish;
  end

endmodule
